// ----- hdl/lr_parse_engine_assert.svh -----
// Assertion macros for the parse engine.
`ifndef LR_PARSE_ENGINE_ASSERT_SVH
`define LR_PARSE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define LRPE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lr_parse_engine assertion failed");

// Next-cycle implication.
`define LRPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lr_parse_engine assertion failed");

`endif

// ----- hdl/lrpe_pkg.sv -----
package lrpe_pkg;

   localparam int NUM_STATES_DEF   = 256;
   localparam int NUM_TOKENS_DEF   = 64;
   localparam int NUM_RULES_DEF    = 128;
   localparam int STACK_DEPTH_DEF  = 64;
   localparam int MAX_RULE_LEN_DEF = 15;
   localparam int SLOT_COUNT_DEF   = 1024;

   localparam int MAX_REDUCE  = 63;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_TOKEN = 2'd0,
      OP_TABLE = 2'd1,
      OP_RULE  = 2'd2,
      OP_START = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      EV_SHIFT    = 3'd0,
      EV_REDUCE   = 3'd1,
      EV_ACCEPT   = 3'd2,
      EV_SYNTAX   = 3'd3,
      EV_LEXER    = 3'd4,
      EV_OVERFLOW = 3'd5,
      EV_LOAD     = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      KIND_ERROR  = 2'd0,
      KIND_SHIFT  = 2'd1,
      KIND_REDUCE = 2'd2,
      KIND_ACCEPT = 2'd3
   } kind_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] token;
      logic       lex_error;
      logic [7:0] state_sel;
      kind_type   entry_kind;
      logic [7:0] entry_target;
      logic [6:0] rule_sel;
      logic [3:0] rule_len;
      logic [5:0] rule_lhs;
   } item_type;

   typedef struct packed {
      event_type  event_res;
      logic [6:0] rule_num;
      logic [3:0] pop_count;
      logic [9:0] slot;
      logic [7:0] state_out;
      logic [5:0] bad_token;
      logic [5:0] last_token;
      logic       last;
   } rsp_type;

endpackage

// ----- hdl/lrpe_ifs.sv -----
interface lrpe_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [5:0] token;
   logic       lex_error;
   logic [7:0] state_sel;
   logic [1:0] entry_kind;
   logic [7:0] entry_target;
   logic [6:0] rule_sel;
   logic [3:0] rule_len;
   logic [5:0] rule_lhs;

   modport source (output valid, op, token, lex_error, state_sel, entry_kind,
                   entry_target, rule_sel, rule_len, rule_lhs, input ready);
   modport sink (input valid, op, token, lex_error, state_sel, entry_kind,
                 entry_target, rule_sel, rule_len, rule_lhs, output ready);
endinterface

interface lrpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [6:0] rule_num;
   logic [3:0] pop_count;
   logic [9:0] slot;
   logic [7:0] state_out;
   logic [5:0] bad_token;
   logic [5:0] last_token;
   logic       last;

   modport source (output valid, event_res, rule_num, pop_count, slot, state_out,
                   bad_token, last_token, last, input ready);
   modport sink (input valid, event_res, rule_num, pop_count, slot, state_out,
                 bad_token, last_token, last, output ready);
endinterface

// ----- hdl/lrpe_ram.sv -----
module lrpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lrpe_front.sv -----
module lrpe_front (
   input  logic                clock,
   input  logic                reset,
   lrpe_req_if.sink            req_chan,
   output logic                item_valid,
   output lrpe_pkg::item_type  item,
   input  logic                item_pop
);
   import lrpe_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   item_type       q_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           push;
   item_type       new_item;

   function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
      return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      new_item.op           = op_type'(req_chan.op);
      new_item.token        = req_chan.token;
      new_item.lex_error    = req_chan.lex_error;
      new_item.state_sel    = req_chan.state_sel;
      new_item.entry_kind   = kind_type'(req_chan.entry_kind);
      new_item.entry_target = req_chan.entry_target;
      new_item.rule_sel     = req_chan.rule_sel;
      new_item.rule_len     = req_chan.rule_len;
      new_item.rule_lhs     = req_chan.rule_lhs;
   end

   assign req_chan.ready = (32'(count_ff) != QUEUE_DEPTH);
   assign push           = req_chan.valid && req_chan.ready;
   assign item_valid     = (count_ff != '0);
   assign item           = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = item_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCW'(push) - QCW'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- hdl/lrpe_back.sv -----
module lrpe_back #(
   parameter int NUM_STATES   = lrpe_pkg::NUM_STATES_DEF,
   parameter int NUM_TOKENS   = lrpe_pkg::NUM_TOKENS_DEF,
   parameter int NUM_RULES    = lrpe_pkg::NUM_RULES_DEF,
   parameter int STACK_DEPTH  = lrpe_pkg::STACK_DEPTH_DEF,
   parameter int MAX_RULE_LEN = lrpe_pkg::MAX_RULE_LEN_DEF,
   parameter int SLOT_COUNT   = lrpe_pkg::SLOT_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  lrpe_pkg::item_type item,
   output logic               item_pop,
   lrpe_rsp_if.source         rsp_chan
);
   import lrpe_pkg::*;

   localparam int ADEPTH = NUM_STATES * NUM_TOKENS;
   localparam int AAW    = $clog2(ADEPTH);
   localparam int RAW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
   localparam int SAW    = $clog2(STACK_DEPTH);
   localparam int STW    = $clog2(STACK_DEPTH + 1);
   localparam int SLW    = $clog2(SLOT_COUNT);
   localparam int SKW    = SLW + 8;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ACT, ST_RULE, ST_POP1, ST_POP2, ST_GOTO
   } state_type;

   state_type      state_ff, state_in;
   item_type       item_ff, item_in;
   logic [7:0]     cur_ff, cur_in;
   logic [STW-1:0] top_ff, top_in;
   logic [SLW-1:0] la_ff, la_in;
   logic [SLW-1:0] rs_ff, rs_in;
   logic [SLW-1:0] idx_ff, idx_in;
   logic [5:0]     prev_ff, prev_in;
   logic           active_ff, active_in;
   logic [5:0]     nred_ff, nred_in;
   logic           oob_ff, oob_in;
   logic [7:0]     tgt_ff, tgt_in;
   logic [3:0]     len_ff, len_in;
   logic [5:0]     lhs_ff, lhs_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           act_we, act_re;
   logic [AAW-1:0] act_waddr, act_raddr;
   logic [9:0]     act_wdata, act_rdata;
   logic           rule_we, rule_re;
   logic [RAW-1:0] rule_waddr, rule_raddr;
   logic [9:0]     rule_wdata, rule_rdata;
   logic           stk_we, stk_re;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [SKW-1:0] stk_wdata, stk_rdata;

   logic           can_emit;
   kind_type       kind;
   logic [7:0]     tgt;
   logic [3:0]     rlen;
   logic [5:0]     rlhs;
   logic [7:0]     new_state;
   logic [3:0]     len_sat;

   function automatic logic in_range(input logic [7:0] row, input logic [5:0] col);
      return (32'(row) < NUM_STATES) && (32'(col) < NUM_TOKENS);
   endfunction

   function automatic logic [AAW-1:0] act_addr(input logic [7:0] row,
                                                input logic [5:0] col);
      return AAW'(32'(row) * NUM_TOKENS + 32'(col));
   endfunction

   function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] x);
      return (32'(x) == SLOT_COUNT - 1) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [9:0] slot10(input logic [SLW-1:0] x);
      logic [31:0] t;
      t = 32'(x);
      return t[9:0];
   endfunction

   function automatic rsp_type mk_rsp(input event_type ev, input logic [7:0] rule,
                                      input logic [3:0] args, input logic [9:0] slot,
                                      input logic [7:0] st, input logic [5:0] bad,
                                      input logic [5:0] prev, input logic last);
      rsp_type r;
      r.event_res  = ev;
      r.rule_num   = rule[6:0];
      r.pop_count  = args;
      r.slot       = slot;
      r.state_out  = st;
      r.bad_token  = bad;
      r.last_token = prev;
      r.last       = last;
      return r;
   endfunction

   lrpe_ram #(.WIDTH(10), .DEPTH(ADEPTH)) u_act (
      .clock(clock), .wr_en(act_we), .wr_addr(act_waddr), .wr_data(act_wdata),
      .rd_en(act_re), .rd_addr(act_raddr), .rd_data(act_rdata)
   );

   lrpe_ram #(.WIDTH(10), .DEPTH(NUM_RULES)) u_rule (
      .clock(clock), .wr_en(rule_we), .wr_addr(rule_waddr), .wr_data(rule_wdata),
      .rd_en(rule_re), .rd_addr(rule_raddr), .rd_data(rule_rdata)
   );

   lrpe_ram #(.WIDTH(SKW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_en(stk_re), .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   assign can_emit  = !rsp_valid_ff || rsp_chan.ready;
   assign kind      = oob_ff ? KIND_ERROR : kind_type'(act_rdata[9:8]);
   assign tgt       = oob_ff ? 8'd0 : act_rdata[7:0];
   assign new_state = tgt;
   assign rlen      = rule_rdata[9:6];
   assign rlhs      = rule_rdata[5:0];
   assign len_sat   = (32'(item.rule_len) > MAX_RULE_LEN) ? 4'(MAX_RULE_LEN)
                                                          : item.rule_len;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      top_in       = top_ff;
      la_in        = la_ff;
      rs_in        = rs_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      active_in    = active_ff;
      nred_in      = nred_ff;
      oob_in       = oob_ff;
      tgt_in       = tgt_ff;
      len_in       = len_ff;
      lhs_in       = lhs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      item_pop     = 1'b0;
      act_we       = 1'b0;
      act_waddr    = act_addr(item.state_sel, item.token);
      act_wdata    = {item.entry_kind, item.entry_target};
      act_re       = 1'b0;
      act_raddr    = act_addr(cur_ff, item_ff.token);
      rule_we      = 1'b0;
      rule_waddr   = RAW'(item.rule_sel);
      rule_wdata   = {len_sat, item.rule_lhs};
      rule_re      = 1'b0;
      rule_raddr   = RAW'(tgt);
      stk_we       = 1'b0;
      stk_waddr    = SAW'(top_ff);
      stk_wdata    = {la_ff, new_state};
      stk_re       = 1'b0;
      stk_raddr    = SAW'(32'(top_ff) - 32'(len_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && can_emit) begin
               item_pop = 1'b1;
               item_in  = item;
               nred_in  = '0;
               unique case (item.op)
                  OP_TABLE: begin
                     act_we       = in_range(item.state_sel, item.token);
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(EV_LOAD, '0, '0, '0, cur_ff, '0, '0, 1'b1);
                  end
                  OP_RULE: begin
                     rule_we      = (32'(item.rule_sel) < NUM_RULES);
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(EV_LOAD, '0, '0, '0, cur_ff, '0, '0, 1'b1);
                  end
                  OP_START: begin
                     stk_we       = 1'b1;
                     stk_waddr    = '0;
                     stk_wdata    = '0;
                     top_in       = STW'(1);
                     cur_in       = '0;
                     la_in        = '0;
                     rs_in        = '0;
                     prev_in      = '0;
                     active_in    = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(EV_LOAD, '0, '0, '0, 8'd0, '0, '0, 1'b1);
                  end
                  OP_TOKEN: begin
                     if (!active_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = mk_rsp(EV_SYNTAX, '0, '0, slot10(la_ff), cur_ff,
                                        item.token, prev_ff, 1'b1);
                     end else if (item.lex_error) begin
                        active_in    = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_in = mk_rsp(EV_LEXER, '0, '0, slot10(la_ff), cur_ff,
                                        '0, '0, 1'b1);
                     end else begin
                        act_re    = 1'b1;
                        act_raddr = act_addr(cur_ff, item.token);
                        oob_in    = !in_range(cur_ff, item.token);
                        state_in  = ST_ACT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_ACT: begin
            if (can_emit) begin
               unique case (kind)
                  KIND_SHIFT: begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                     if (32'(top_ff) >= STACK_DEPTH) begin
                        active_in = 1'b0;
                        rsp_in = mk_rsp(EV_OVERFLOW, '0, '0, '0, cur_ff, '0, '0, 1'b1);
                     end else begin
                        stk_we  = 1'b1;
                        cur_in  = new_state;
                        top_in  = top_ff + 1'b1;
                        prev_in = item_ff.token;
                        la_in   = slot_inc(la_ff);
                        rsp_in = mk_rsp(EV_SHIFT, '0, '0, slot10(la_ff), new_state,
                                        '0, '0, 1'b1);
                     end
                  end
                  KIND_ACCEPT: begin
                     state_in     = ST_IDLE;
                     active_in    = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(EV_ACCEPT, '0, '0, slot10(rs_ff), cur_ff,
                                     '0, '0, 1'b1);
                  end
                  default: begin
                     if (kind == KIND_ERROR || 32'(tgt) >= NUM_RULES) begin
                        state_in     = ST_IDLE;
                        active_in    = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_in = mk_rsp(EV_SYNTAX, '0, '0, slot10(la_ff), cur_ff,
                                        item_ff.token, prev_ff, 1'b1);
                     end else begin
                        rule_re  = 1'b1;
                        tgt_in   = tgt;
                        state_in = ST_RULE;
                     end
                  end
               endcase
            end
         end

         ST_RULE: begin
            if (can_emit) begin
               len_in = rlen;
               lhs_in = rlhs;
               if (32'(nred_ff) >= MAX_REDUCE || 32'(top_ff) < 32'(rlen) + 1 ||
                   (rlen == 4'd0 && 32'(top_ff) >= STACK_DEPTH)) begin
                  state_in     = ST_IDLE;
                  active_in    = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in = mk_rsp(EV_OVERFLOW, '0, '0, '0, cur_ff, '0, '0, 1'b1);
               end else if (rlen != 4'd0) begin
                  stk_re    = 1'b1;
                  stk_raddr = SAW'(32'(top_ff) - 32'(rlen));
                  state_in  = ST_POP1;
               end else begin
                  idx_in    = rs_ff;
                  act_re    = 1'b1;
                  act_raddr = act_addr(cur_ff, rlhs);
                  oob_in    = !in_range(cur_ff, rlhs);
                  state_in  = ST_GOTO;
               end
            end
         end

         ST_POP1: begin
            idx_in    = stk_rdata[SKW-1:8];
            stk_re    = 1'b1;
            stk_raddr = SAW'(32'(top_ff) - 32'(len_ff) - 1);
            state_in  = ST_POP2;
         end

         ST_POP2: begin
            act_re    = 1'b1;
            act_raddr = act_addr(stk_rdata[7:0], lhs_ff);
            oob_in    = !in_range(stk_rdata[7:0], lhs_ff);
            state_in  = ST_GOTO;
         end

         ST_GOTO: begin
            if (can_emit) begin
               stk_we       = 1'b1;
               stk_waddr    = SAW'(32'(top_ff) - 32'(len_ff));
               stk_wdata    = {idx_ff, new_state};
               top_in       = STW'(32'(top_ff) - 32'(len_ff) + 1);
               rs_in        = idx_ff;
               la_in        = (la_ff != idx_ff) ? slot_inc(idx_ff) : la_ff;
               prev_in      = lhs_ff;
               cur_in       = new_state;
               nred_in      = nred_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(EV_REDUCE, tgt_ff, len_ff, slot10(idx_ff), new_state,
                               '0, '0, 1'b0);
               act_re    = 1'b1;
               act_raddr = act_addr(new_state, item_ff.token);
               oob_in    = !in_range(new_state, item_ff.token);
               state_in  = ST_ACT;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         top_ff       <= '0;
         la_ff        <= '0;
         rs_ff        <= '0;
         prev_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         top_ff       <= top_in;
         la_ff        <= la_in;
         rs_ff        <= rs_in;
         prev_ff      <= prev_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      idx_ff  <= idx_in;
      nred_ff <= nred_in;
      oob_ff  <= oob_in;
      tgt_ff  <= tgt_in;
      len_ff  <= len_in;
      lhs_ff  <= lhs_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.event_res  = rsp_ff.event_res;
   assign rsp_chan.rule_num   = rsp_ff.rule_num;
   assign rsp_chan.pop_count  = rsp_ff.pop_count;
   assign rsp_chan.slot       = rsp_ff.slot;
   assign rsp_chan.state_out  = rsp_ff.state_out;
   assign rsp_chan.bad_token  = rsp_ff.bad_token;
   assign rsp_chan.last_token = rsp_ff.last_token;
   assign rsp_chan.last       = rsp_ff.last;

endmodule

// ----- hdl/lr_parse_engine.sv -----
// Table-driven LR parse engine. Load items write the action/goto table and the
// rule table and answer one load done event; a start item resets the parse
// stack to state 0. A token item runs the driver: each action lookup is one
// read of the action table memory; each reduction adds a rule table read,
// two parse stack reads (none when the rule is empty) and a goto read. One
// item is worked at a time by the back end; a two-entry queue takes new
// items while it is busy and a result register holds each event until it
// is taken, the back end stalling while that register is full. Tables come
// up undefined and need no clearing pass.
`include "lr_parse_engine_assert.svh"

module lr_parse_engine #(
   parameter int NUM_STATES   = lrpe_pkg::NUM_STATES_DEF,
   parameter int NUM_TOKENS   = lrpe_pkg::NUM_TOKENS_DEF,
   parameter int NUM_RULES    = lrpe_pkg::NUM_RULES_DEF,
   parameter int STACK_DEPTH  = lrpe_pkg::STACK_DEPTH_DEF,
   parameter int MAX_RULE_LEN = lrpe_pkg::MAX_RULE_LEN_DEF,
   parameter int SLOT_COUNT   = lrpe_pkg::SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lrpe_req_if.sink    req_chan,
   lrpe_rsp_if.source  rsp_chan
);
   import lrpe_pkg::*;

   logic     item_valid;
   logic     item_pop;
   item_type item;

   lrpe_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .item_valid(item_valid), .item(item), .item_pop(item_pop)
   );

   lrpe_back #(
      .NUM_STATES(NUM_STATES), .NUM_TOKENS(NUM_TOKENS), .NUM_RULES(NUM_RULES),
      .STACK_DEPTH(STACK_DEPTH), .MAX_RULE_LEN(MAX_RULE_LEN),
      .SLOT_COUNT(SLOT_COUNT)
   ) u_back (
      .clock(clock), .reset(reset), .item_valid(item_valid), .item(item),
      .item_pop(item_pop), .rsp_chan(rsp_chan)
   );

   `LRPE_ASSERT_IMPL(a_last_unless_reduce, clock, reset, rsp_chan.valid, rsp_chan.last == (rsp_chan.event_res != EV_REDUCE))
   `LRPE_ASSERT_IMPL(a_tokens_only_on_syntax, clock, reset, rsp_chan.valid && rsp_chan.event_res != EV_SYNTAX, rsp_chan.bad_token == 6'd0 && rsp_chan.last_token == 6'd0)
   `LRPE_ASSERT_IMPL(a_load_is_plain, clock, reset, rsp_chan.valid && rsp_chan.event_res == EV_LOAD, rsp_chan.slot == 10'd0 && rsp_chan.rule_num == 7'd0)
   `LRPE_ASSERT_IMPL(a_pop_needs_item, clock, reset, !item_valid, !item_pop)

endmodule

// ----- verif/tb_lr_parse_engine.sv -----
`timescale 1ns / 100ps

import lrpe_pkg::*;

class parse_scoreboard;
   logic [9:0]  act_mem[16384];
   bit          act_set[16384];
   logic [9:0]  rule_mem[128];
   bit          rule_set[128];
   logic [9:0]  stk_slot[64];
   logic [7:0]  stk_state[64];
   int unsigned depth;
   logic [7:0]  cur_state;
   logic [9:0]  la_slot;
   logic [9:0]  red_slot;
   logic [5:0]  last_tok;
   bit          active;
   rsp_type     events[$];
   int unsigned fails;

   function new();
      depth = 0;
      cur_state = 0;
      la_slot = 0;
      red_slot = 0;
      last_tok = 0;
      active = 0;
      fails = 0;
   endfunction

   static function rsp_type mk_event(event_type e, logic [6:0] r, logic [3:0] a,
                                     logic [9:0] s, logic [7:0] st,
                                     logic [5:0] b, logic [5:0] p);
      rsp_type x;
      x.event_res = e;
      x.rule_num = r;
      x.pop_count = a;
      x.slot = s;
      x.state_out = st;
      x.bad_token = b;
      x.last_token = p;
      x.last = 1'b0;
      return x;
   endfunction

   // Runs the driver for one token on copies of the parse state. Returns the
   // index of the first unwritten table entry it would read (rules offset by
   // 16384), or -1; only with commit are the events and the state kept.
   function int walk_token(item_type it, bit commit);
      logic [9:0]  sl[64];
      logic [7:0]  st[64];
      int unsigned d;
      logic [7:0]  cs;
      logic [9:0]  la, rs, dst;
      logic [5:0]  pv, lhs;
      bit          a, done;
      rsp_type     q[$];
      logic [13:0] idx;
      kind_type    kind;
      logic [7:0]  tgt;
      logic [3:0]  len;
      sl = stk_slot;
      st = stk_state;
      d = depth;
      cs = cur_state;
      la = la_slot;
      rs = red_slot;
      pv = last_tok;
      a = active;
      if (!a) begin
         q.push_back(mk_event(EV_SYNTAX, 0, 0, la, cs, it.token, pv));
      end else if (it.lex_error) begin
         q.push_back(mk_event(EV_LEXER, 0, 0, la, cs, 0, 0));
         a = 0;
      end else begin
         done = 0;
         while (!done) begin
            idx = {cs, it.token};
            if (!act_set[idx]) return int'(idx);
            kind = kind_type'(act_mem[idx][9:8]);
            tgt = act_mem[idx][7:0];
            done = 1;
            if (kind == KIND_SHIFT) begin
               if (d >= 64) begin
                  q.push_back(mk_event(EV_OVERFLOW, 0, 0, 0, cs, 0, 0));
                  a = 0;
               end else begin
                  cs = tgt;
                  sl[d] = la;
                  st[d] = cs;
                  d++;
                  q.push_back(mk_event(EV_SHIFT, 0, 0, la, cs, 0, 0));
                  pv = it.token;
                  la = la + 10'd1;
               end
            end else if (kind == KIND_ACCEPT) begin
               q.push_back(mk_event(EV_ACCEPT, 0, 0, rs, cs, 0, 0));
               a = 0;
            end else if (kind == KIND_ERROR || tgt >= 128) begin
               q.push_back(mk_event(EV_SYNTAX, 0, 0, la, cs, it.token, pv));
               a = 0;
            end else begin
               if (!rule_set[tgt[6:0]]) return 16384 + int'(tgt);
               len = rule_mem[tgt[6:0]][9:6];
               lhs = rule_mem[tgt[6:0]][5:0];
               if (q.size() >= MAX_REDUCE || d < int'(len) + 1 || (len == 0 && d >= 64)) begin
                  q.push_back(mk_event(EV_OVERFLOW, 0, 0, 0, cs, 0, 0));
                  a = 0;
               end else begin
                  dst = rs;
                  repeat (len) begin
                     d--;
                     dst = sl[d];
                  end
                  idx = {st[d - 1], lhs};
                  if (!act_set[idx]) return int'(idx);
                  cs = act_mem[idx][7:0];
                  sl[d] = dst;
                  st[d] = cs;
                  d++;
                  rs = dst;
                  if (la != dst) la = dst + 10'd1;
                  pv = lhs;
                  q.push_back(mk_event(EV_REDUCE, tgt[6:0], len, dst, cs, 0, 0));
                  done = 0;
               end
            end
         end
      end
      if (commit) begin
         q[q.size() - 1].last = 1'b1;
         foreach (q[i]) events.push_back(q[i]);
         stk_slot = sl;
         stk_state = st;
         depth = d;
         cur_state = cs;
         la_slot = la;
         red_slot = rs;
         last_tok = pv;
         active = a;
      end
      return -1;
   endfunction

   function void note_item(item_type it);
      rsp_type x;
      case (it.op)
         OP_TABLE: begin
            act_mem[{it.state_sel, it.token}] = {it.entry_kind, it.entry_target};
            act_set[{it.state_sel, it.token}] = 1;
         end
         OP_RULE: begin
            rule_mem[it.rule_sel] = {it.rule_len, it.rule_lhs};
            rule_set[it.rule_sel] = 1;
         end
         OP_START: begin
            stk_slot[0] = 0;
            stk_state[0] = 0;
            depth = 1;
            cur_state = 0;
            la_slot = 0;
            red_slot = 0;
            last_tok = 0;
            active = 1;
         end
         default: begin
            void'(walk_token(it, 1));
            return;
         end
      endcase
      x = mk_event(EV_LOAD, 0, 0, 0, cur_state, 0, 0);
      x.last = 1'b1;
      events.push_back(x);
   endfunction

   function void cmp_field(string name, int e, int g);
      if (e != g) begin
         fails++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, g);
      end
   endfunction

   function void check_event(rsp_type got);
      rsp_type e;
      if (events.size() == 0) begin
         fails++;
         $display("%0t: unexpected transfer: expected none, actual %p", $time, got);
         return;
      end
      e = events.pop_front();
      cmp_field("event_res", e.event_res, got.event_res);
      cmp_field("rule_num", e.rule_num, got.rule_num);
      cmp_field("pop_count", e.pop_count, got.pop_count);
      cmp_field("slot", e.slot, got.slot);
      cmp_field("state_out", e.state_out, got.state_out);
      cmp_field("bad_token", e.bad_token, got.bad_token);
      cmp_field("last_token", e.last_token, got.last_token);
      cmp_field("last", e.last, got.last);
   endfunction
endclass

module tb_lr_parse_engine;
   localparam int ITEM_W = $bits(item_type);
   logic clock = 0;
   logic reset = 1;
   lrpe_req_if req ();
   lrpe_rsp_if rsp ();
   parse_scoreboard sb = new();
   int unsigned cycles = 0;
   int unsigned items = 0;
   int unsigned hold = 0;
   bit burst = 0;

   lr_parse_engine dut (.clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp));

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            sb.check_event({event_type'(rsp.event_res), rsp.rule_num, rsp.pop_count,
                            rsp.slot, rsp.state_out, rsp.bad_token, rsp.last_token,
                            rsp.last});
            hold = burst ? 0 : $urandom_range(0, 14);
         end
         if (hold > 0) begin
            rsp.ready <= 1'b0;
            hold--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   function automatic item_type rand_item(op_type op);
      item_type it;
      it = item_type'(ITEM_W'({$urandom, $urandom}));
      it.op = op;
      it.lex_error = 0;
      return it;
   endfunction

   task automatic send(item_type it);
      int unsigned gap;
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.op <= it.op;
      req.token <= it.token;
      req.lex_error <= it.lex_error;
      req.state_sel <= it.state_sel;
      req.entry_kind <= it.entry_kind;
      req.entry_target <= it.entry_target;
      req.rule_sel <= it.rule_sel;
      req.rule_len <= it.rule_len;
      req.rule_lhs <= it.rule_lhs;
      do @(posedge clock); while (!req.ready);
      sb.note_item(it);
      items++;
   endtask

   task automatic write_entry(logic [7:0] row, logic [5:0] col, kind_type k, logic [7:0] tgt);
      item_type it;
      it = rand_item(OP_TABLE);
      it.state_sel = row;
      it.token = col;
      it.entry_kind = k;
      it.entry_target = tgt;
      send(it);
   endtask

   task automatic write_rule(logic [6:0] r, logic [3:0] len, logic [5:0] lhs);
      item_type it;
      it = rand_item(OP_RULE);
      it.rule_sel = r;
      it.rule_len = len;
      it.rule_lhs = lhs;
      send(it);
   endtask

   // Fills whatever entries the token's run would read, then sends it.
   task automatic send_token(logic [5:0] tok, bit lexerr);
      item_type it;
      int miss;
      int unsigned p;
      kind_type k;
      logic [7:0] tgt;
      it = rand_item(OP_TOKEN);
      it.token = tok;
      it.lex_error = lexerr;
      miss = sb.walk_token(it, 0);
      while (miss >= 0) begin
         if (miss >= 16384) begin
            p = $urandom_range(0, 99);
            write_rule(7'(miss - 16384),
                       4'(p < 85 ? $urandom_range(0, 3) : $urandom_range(0, 15)),
                       6'(p < 90 ? $urandom_range(8, 11) : $urandom_range(0, 63)));
         end else begin
            p = $urandom_range(0, 99);
            k = p < 45 ? KIND_SHIFT : p < 80 ? KIND_REDUCE : p < 88 ? KIND_ACCEPT
                : KIND_ERROR;
            p = $urandom_range(0, 99);
            if (k == KIND_REDUCE)
               tgt = 8'(p < 90 ? $urandom_range(0, 7) : $urandom_range(0, 255));
            else
               tgt = 8'(p < 92 ? $urandom_range(0, 7) : $urandom_range(0, 255));
            write_entry(miss[13:6], miss[5:0], k, tgt);
         end
         miss = sb.walk_token(it, 0);
      end
      send(it);
   endtask

   initial begin
      int unsigned p;
      req.valid <= 1'b0;
      req.op <= OP_TOKEN;
      req.token <= 0;
      req.lex_error <= 0;
      req.state_sel <= 0;
      req.entry_kind <= KIND_ERROR;
      req.entry_target <= 0;
      req.rule_sel <= 0;
      req.rule_len <= 0;
      req.rule_lhs <= 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // token while idle, field extremes, lexer error, long empty-rule run
      send_token(6'd63, 0);
      write_entry(8'd255, 6'd63, KIND_ACCEPT, 8'd255);
      write_rule(7'd127, 4'd15, 6'd63);
      write_rule(7'd0, 4'd0, 6'd0);
      write_entry(8'd0, 6'd5, KIND_REDUCE, 8'd1);
      write_rule(7'd1, 4'd0, 6'd9);
      write_entry(8'd0, 6'd9, KIND_SHIFT, 8'd0);
      write_entry(8'd0, 6'd1, KIND_SHIFT, 8'd2);
      write_entry(8'd2, 6'd2, KIND_REDUCE, 8'd200);
      write_entry(8'd2, 6'd3, KIND_ERROR, 8'd0);
      write_entry(8'd2, 6'd4, KIND_ACCEPT, 8'd0);
      send(rand_item(OP_START));
      send_token(6'd5, 0);
      send(rand_item(OP_START));
      send_token(6'd1, 0);
      send_token(6'd2, 0);
      send(rand_item(OP_START));
      send_token(6'd1, 1);
      send(rand_item(OP_START));
      send_token(6'd1, 0);
      send_token(6'd3, 0);
      send(rand_item(OP_START));
      send_token(6'd1, 0);
      send_token(6'd4, 0);

      while (items < 320) begin
         if ($urandom_range(0, 19) == 0) burst = ~burst;
         p = $urandom_range(0, 99);
         if (p < 8 || (!sb.active && p < 40)) begin
            send(rand_item(OP_START));
         end else if (p < 12) begin
            send(rand_item($urandom_range(0, 1) ? OP_TABLE : OP_RULE));
         end else begin
            send_token(6'($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                          : $urandom_range(0, 7)), $urandom_range(0, 29) == 0);
         end
      end
      req.valid <= 1'b0;
      burst = 0;
      while (sb.events.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
